### rtl/sfk_pkg.sv
// ----------------------------------------------------------------------------
// sfk_pkg: shared types and constants for the symmetric flow key parser
// Holds the frame summary passed from the capture front to the key emitter.
// ----------------------------------------------------------------------------
package sfk_pkg;

  localparam int DefMaxCapture = 16384;

  localparam logic [15:0] KIND_IPV4 = 16'h0800;
  localparam logic [15:0] KIND_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  // One finished frame. Addresses are already ordered larger first.
  typedef struct packed {
    logic         ok;
    logic         v6;
    logic         kept;
    logic [15:0]  kind;
    logic [127:0] first;    // byte 0 in bits [127:120]
    logic [127:0] second;
    logic [7:0]   proto;
    logic [31:0]  tail;     // four bytes taken from the L4 header, first in [31:24]
    logic [6:0]   l4_off;
    logic [7:0]   pay_off;
  } frame_sum_t;

endpackage

### rtl/sfk_front.sv
// ----------------------------------------------------------------------------
// sfk_front: frame byte capture
// Tracks byte position, captures header fields and builds one frame summary
// at the byte marked last.
// ----------------------------------------------------------------------------
module sfk_front import sfk_pkg::*; #(
  parameter int MAX_CAPTURE_BYTES = DefMaxCapture
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       sum_valid,
  input  logic       sum_ready,
  output frame_sum_t sum
);

  localparam int PW = $clog2(MAX_CAPTURE_BYTES + 1);

  logic [PW-1:0]  pos;
  logic [15:0]    kind;
  logic [3:0]     ver;
  logic [3:0]     ihl;
  logic [7:0]     proto;
  logic [7:0]     src [16];
  logic [7:0]     dst [16];
  logic [1:0]     cmp;          // 0 equal, 1 source greater, 2 source less
  logic [7:0]     l4b [4];
  logic [3:0]     thl;

  logic           is4, is6, take;
  logic [PW-1:0]  pos_eff;      // position after this byte
  logic [6:0]     l4s;
  logic [PW:0]    p, rel;
  frame_sum_t     sum_next;

  assign is4 = (kind == KIND_IPV4) && (ver == 4'd4);
  assign is6 = (kind == KIND_IPV6) && (ver == 4'd6);
  assign l4s = is4 ? (7'd14 + {1'b0, ihl, 2'b00}) : 7'd54;
  assign p   = {1'b0, pos};
  assign rel = p - {{(PW-6){1'b0}}, l4s};

  assign in_ready = !sum_valid || sum_ready;
  assign take     = in_valid && in_ready;
  assign pos_eff  = (pos < PW'(MAX_CAPTURE_BYTES)) ? pos + 1'b1 : pos;

  // Build summary from the registered state plus the last byte.
  always_comb begin
    logic [7:0]  s_arr [16];
    logic [7:0]  d_arr [16];
    logic [7:0]  h    [4];
    logic [3:0]  th;
    logic [1:0]  c;
    logic [PW:0] cap, need;
    logic        l4ok, kept;
    logic [127:0] sa, da;
    logic [7:0]  pr;
    logic [8:0]  pay;
    s_arr = src; d_arr = dst; h = l4b; th = thl; c = cmp; pr = proto;
    need = '0;
    l4ok = 1'b0;
    // the last byte may itself be a captured field
    if (pos < PW'(MAX_CAPTURE_BYTES) && pos >= PW'(15)) begin
      if (is4) begin
        if (p == 23) pr = in_byte;
        if (p >= 26 && p < 30) s_arr[pos[3:0] - 4'd10] = in_byte;
        if (p >= 30 && p < 34) begin
          d_arr[pos[3:0] - 4'd14] = in_byte;
          if (c == 2'd0) begin
            if (src[pos[3:0] - 4'd14] > in_byte) c = 2'd1;
            else if (src[pos[3:0] - 4'd14] < in_byte) c = 2'd2;
          end
        end
      end else if (is6) begin
        if (p == 20) pr = in_byte;
        if (p >= 22 && p < 38) s_arr[pos[3:0] - 4'd6] = in_byte;
        if (p >= 38 && p < 54) begin
          d_arr[pos[3:0] - 4'd6] = in_byte;
          if (c == 2'd0) begin
            if (src[pos[3:0] - 4'd6] > in_byte) c = 2'd1;
            else if (src[pos[3:0] - 4'd6] < in_byte) c = 2'd2;
          end
        end
      end
      if ((is4 || is6) && p >= {1'b0, PW'(l4s)} && rel < 4) h[rel[1:0]] = in_byte;
      if ((is4 || is6) && rel == 12 && p >= {1'b0, PW'(l4s)}) th = in_byte[7:4];
    end
    for (int i = 0; i < 16; i++) begin
      sa[127-8*i -: 8] = s_arr[i];
      da[127-8*i -: 8] = d_arr[i];
    end
    kept = (c == 2'd1);
    cap  = {1'b0, pos_eff};
    sum_next = '0;
    sum_next.ok = (cap >= 15) && ((is4 && cap >= 34) || (is6 && cap >= 54));
    sum_next.v6 = is6;
    sum_next.kept = kept;
    sum_next.kind = kind;
    sum_next.proto = pr;
    if (is6) begin
      sum_next.first  = kept ? sa : da;
      sum_next.second = kept ? da : sa;
    end else begin
      sum_next.first  = {(kept ? sa[127:96] : da[127:96]), 96'd0};
      sum_next.second = {(kept ? da[127:96] : sa[127:96]), 96'd0};
    end
    sum_next.l4_off = l4s;
    pay = '0;
    if (pr == PROTO_ICMP || pr == PROTO_ICMPV6) begin
      need = {1'b0, PW'(l4s)} + ((pr == PROTO_ICMP) ? (PW+1)'(28) : (PW+1)'(8));
      if (need <= cap) sum_next.tail = {h[0], h[1], 16'd0};
    end else begin
      if (pr == PROTO_TCP && {1'b0, PW'(l4s)} + 20 <= cap) begin
        l4ok = 1'b1;
        pay = {2'b0, l4s} + {3'b0, th, 2'b00};
      end else if (pr == PROTO_UDP && {1'b0, PW'(l4s)} + 8 <= cap) begin
        l4ok = 1'b1;
        pay = {2'b0, l4s} + 9'd8;
      end
      if (l4ok) sum_next.tail = kept ? {h[0], h[1], h[2], h[3]}
                                     : {h[2], h[3], h[0], h[1]};
    end
    sum_next.pay_off = pay[7:0];
    if (!sum_next.ok) begin
      sum_next.kept = 1'b0;
      sum_next.l4_off = '0;
      sum_next.pay_off = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; kind <= '0; ver <= '0; ihl <= '0; proto <= '0;
      cmp <= 2'd0; thl <= '0; sum_valid <= 1'b0;
      for (int i = 0; i < 4; i++) l4b[i] <= '0;
    end else begin
      if (sum_ready && !(take && in_last)) sum_valid <= 1'b0;
      if (take) begin
        if (in_last) begin
          sum <= sum_next;
          sum_valid <= 1'b1;
          pos <= '0; kind <= '0; ver <= '0; ihl <= '0; proto <= '0;
          cmp <= 2'd0; thl <= '0;
          for (int i = 0; i < 4; i++) l4b[i] <= '0;
        end else if (pos < PW'(MAX_CAPTURE_BYTES)) begin
          pos <= pos + 1'b1;
          if (pos == PW'(12)) kind <= {in_byte, 8'd0};
          if (pos == PW'(13)) kind <= {kind[15:8], in_byte};
          if (pos == PW'(14)) begin
            ver <= in_byte[7:4];
            ihl <= in_byte[3:0];
          end
          if (pos >= PW'(15) && (is4 || is6)) begin
            if (is4 && p == 23) proto <= in_byte;
            if (is6 && p == 20) proto <= in_byte;
            if (is4 && p >= 26 && p < 30) src[pos[3:0] - 4'd10] <= in_byte;
            if (is6 && p >= 22 && p < 38) src[pos[3:0] - 4'd6] <= in_byte;
            if (is4 && p >= 30 && p < 34) begin
              dst[pos[3:0] - 4'd14] <= in_byte;
              if (cmp == 2'd0) begin
                if (src[pos[3:0] - 4'd14] > in_byte) cmp <= 2'd1;
                else if (src[pos[3:0] - 4'd14] < in_byte) cmp <= 2'd2;
              end
            end
            if (is6 && p >= 38 && p < 54) begin
              dst[pos[3:0] - 4'd6] <= in_byte;
              if (cmp == 2'd0) begin
                if (src[pos[3:0] - 4'd6] > in_byte) cmp <= 2'd1;
                else if (src[pos[3:0] - 4'd6] < in_byte) cmp <= 2'd2;
              end
            end
            if (p >= {1'b0, PW'(l4s)} && rel < 4) l4b[rel[1:0]] <= in_byte;
            if (p >= {1'b0, PW'(l4s)} && rel == 12) thl <= in_byte[7:4];
          end
        end
      end
    end
  end

endmodule

### rtl/sfk_back.sv
// ----------------------------------------------------------------------------
// sfk_back: key emitter
// Walks a summary via an output register, one key byte per unstalled cycle.
// ----------------------------------------------------------------------------
module sfk_back import sfk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sum_valid,
  output logic       sum_ready,
  input  frame_sum_t sum,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_ok,
  output logic       out_kept,
  output logic [6:0] out_l4,
  output logic [7:0] out_pay
);

  logic [5:0] idx;
  logic [5:0] len;
  logic [7:0] b;
  logic       adv;

  assign len = !sum.ok ? 6'd1 : (sum.v6 ? 6'd39 : 6'd15);
  assign adv = sum_valid && (!out_valid || out_ready);
  assign sum_ready = adv && (idx == len - 6'd1);

  always_comb begin
    logic [5:0] al;
    logic [5:0] al2;
    logic [5:0] k;
    al  = sum.v6 ? 6'd16 : 6'd4;
    al2 = {al[4:0], 1'b0};
    k   = '0;
    b = 8'd0;
    if (!sum.ok) b = 8'd0;
    else if (idx == 6'd0) b = sum.kind[15:8];
    else if (idx == 6'd1) b = sum.kind[7:0];
    else if (idx < 6'd2 + al) begin
      k = idx - 6'd2;
      b = sum.first[127 - 8*k[3:0] -: 8];
    end else if (idx < 6'd2 + al2) begin
      k = idx - 6'd2 - al;
      b = sum.second[127 - 8*k[3:0] -: 8];
    end else if (idx == 6'd2 + al2) b = sum.proto;
    else begin
      k = idx - 6'd3 - al2;
      b = sum.tail[31 - 8*k[1:0] -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        out_byte <= b;
        out_last <= (idx == len - 6'd1);
        out_ok <= sum.ok;
        out_kept <= sum.kept;
        out_l4 <= sum.l4_off;
        out_pay <= sum.pay_off;
        idx <= (idx == len - 6'd1) ? 6'd0 : idx + 6'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/symmetric_flow_key_parser.sv
// ----------------------------------------------------------------------------
// symmetric_flow_key_parser: direction-free five-tuple key from Ethernet frames
// Byte-wide frame in, byte-wide key out.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle on s_axis while s_axis_tready is high. At
// the byte marked tlast the capture front hands a finished frame summary to a
// one-entry hand-off register; the emitter then sends the key one byte a cycle
// on m_axis while m_axis_tready holds: 15 bytes for IPv4, 39 for IPv6, or one
// zero byte with ok clear on failure. The first key byte passes through the
// hand-off register and then the emitter's output register. The hand-off
// register stays full until the emitter loads the last key byte, and the front
// takes nothing while it is full, so the next frame's first byte waits for that
// load; every m_axis stall during the key lengthens the wait.
module symmetric_flow_key_parser import sfk_pkg::*; #(
  parameter int MAX_CAPTURE_BYTES = DefMaxCapture
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pkt_byte
  input  logic        s_axis_tlast,   // pkt_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // key_byte[7:0], order_kept, l4_start[6:0], pay_start[7:0]
  output logic        m_axis_tlast,   // key_last
  output logic        m_axis_tuser    // key_ok
);

  logic       sum_valid, sum_ready;
  frame_sum_t sum;
  logic [7:0] kb, po;
  logic       kk;
  logic [6:0] lo;

  sfk_front #(.MAX_CAPTURE_BYTES(MAX_CAPTURE_BYTES)) u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .sum_valid, .sum_ready, .sum
  );

  sfk_back u_back (
    .clk, .rst,
    .sum_valid, .sum_ready, .sum,
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (kb),
    .out_last  (m_axis_tlast),
    .out_ok    (m_axis_tuser),
    .out_kept  (kk),
    .out_l4    (lo),
    .out_pay   (po)
  );

  assign m_axis_tdata = {po, lo, kk, kb};

`ifndef SYNTHESIS
  // a failed key carries no byte and no offsets
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0 && m_axis_tlast)
    else $error("failure result not empty");
  // input is never refused unless a summary is waiting
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !sum_valid |-> s_axis_tready)
    else $error("front stalled with empty hand-off");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the symmetric flow key parser
// Sends Ethernet frames byte by byte, predicts each direction-free key byte
// and compares every received key byte against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sfk_pkg::*;

  // small capture limit so saturation is reached with a short frame
  localparam int TbMaxCapture = 64;

  typedef struct packed {
    logic [7:0] kbyte;
    logic       klast;
    logic       ok;
    logic       kept;
    logic [6:0] l4_off;
    logic [7:0] pay_off;
  } key_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  symmetric_flow_key_parser #(.MAX_CAPTURE_BYTES(TbMaxCapture)) dut (.*);

  always #2 clk = ~clk;

  // predictor state for the frame in flight
  int unsigned pos;
  logic [15:0] kind;
  logic [3:0]  ver, ihl, thl;
  logic [7:0]  proto;
  logic [7:0]  src_a [16];
  logic [7:0]  dst_a [16];
  logic [1:0]  cmp;          // 0 equal, 1 source greater, 2 source less
  logic [7:0]  l4h [4];

  key_beat_t key_q[$];
  int errors = 0;
  int rx_wait = 0;
  longint cycles = 0;
  bit stim_done = 0;

  function automatic bit is_v4();
    return kind == KIND_IPV4 && ver == 4;
  endfunction
  function automatic bit is_v6();
    return kind == KIND_IPV6 && ver == 6;
  endfunction
  function automatic int unsigned l4_at();
    return is_v4() ? 14 + 4 * ihl : 54;
  endfunction

  function automatic void clear_frame();
    pos = 0; kind = 0; ver = 0; ihl = 0; proto = 0; cmp = 0; thl = 0;
    foreach (l4h[i]) l4h[i] = 0;
  endfunction

  function automatic void take_byte(int unsigned p, logic [7:0] b);
    int unsigned s;
    if (p == 12) kind[15:8] = b;
    if (p == 13) kind[7:0] = b;
    if (p == 14) {ver, ihl} = b;
    if (p < 15) return;
    if (is_v4()) begin
      if (p == 23) proto = b;
      if (p >= 26 && p < 30) src_a[p-26] = b;
      if (p >= 30 && p < 34) begin
        dst_a[p-30] = b;
        if (cmp == 0 && src_a[p-30] != b) cmp = src_a[p-30] > b ? 2'd1 : 2'd2;
      end
    end else if (is_v6()) begin
      if (p == 20) proto = b;
      if (p >= 22 && p < 38) src_a[p-22] = b;
      if (p >= 38 && p < 54) begin
        dst_a[p-38] = b;
        if (cmp == 0 && src_a[p-38] != b) cmp = src_a[p-38] > b ? 2'd1 : 2'd2;
      end
    end else return;
    s = l4_at();
    if (p >= s && p < s + 4) l4h[p-s] = b;
    if (p == s + 12) thl = b[7:4];
  endfunction

  // builds the expected key beats at the end of a frame
  function automatic void predict_key();
    logic [7:0] k[$];
    logic [7:0] a[4];
    int unsigned alen, s, pay, caplen;
    bit kept, good;
    key_beat_t kb;
    caplen = pos;
    good = caplen >= 15 && ((is_v4() && caplen >= 34) || (is_v6() && caplen >= 54));
    if (!good) begin
      kb = '0; kb.klast = 1; key_q = {key_q, kb}; return;
    end
    alen = is_v4() ? 4 : 16;
    s = l4_at(); pay = 0; kept = (cmp == 1);
    foreach (a[i]) a[i] = 0;
    k = {k, kind[15:8]}; k = {k, kind[7:0]};
    for (int i = 0; i < alen; i++) k = {k, (kept ? src_a[i] : dst_a[i])};
    for (int i = 0; i < alen; i++) k = {k, (kept ? dst_a[i] : src_a[i])};
    k = {k, proto};
    if (proto == PROTO_ICMP || proto == PROTO_ICMPV6) begin
      if (s + (proto == PROTO_ICMP ? 28 : 8) <= caplen) begin a[0] = l4h[0]; a[1] = l4h[1]; end
    end else if ((proto == PROTO_TCP && s + 20 <= caplen) ||
                 (proto == PROTO_UDP && s + 8 <= caplen)) begin
      pay = proto == PROTO_TCP ? s + 4 * thl : s + 8;
      if (kept) a = '{l4h[0], l4h[1], l4h[2], l4h[3]};
      else a = '{l4h[2], l4h[3], l4h[0], l4h[1]};
    end
    foreach (a[i]) k = {k, a[i]};
    foreach (k[i]) begin
      kb.kbyte = k[i]; kb.klast = (i == k.size() - 1); kb.ok = 1; kb.kept = kept;
      kb.l4_off = s[6:0]; kb.pay_off = pay[7:0];
      key_q = {key_q, kb};
    end
  endfunction

  // sends one frame byte and updates the prediction once it is accepted
  task automatic send_byte(logic [7:0] b, bit last);
    int unsigned gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= b; s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (pos < TbMaxCapture) begin take_byte(pos, b); pos++; end
    if (last) begin predict_key(); clear_frame(); end
  endtask

  task automatic send_frame(logic [7:0] f[$]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // builds a frame; kind_sel 0 IPv4, 1 IPv6, 2 random header
  function automatic void make_frame(output logic [7:0] f[$], input int kind_sel,
                                     input logic [7:0] pr, input int len, input bit same_addr);
    f = {};
    for (int i = 0; i < len; i++) f = {f, 8'($urandom_range(0, 255))};
    if (kind_sel == 2) return;
    if (len > 13) begin
      f[12] = kind_sel ? 8'h86 : 8'h08; f[13] = kind_sel ? 8'hDD : 8'h00;
    end
    if (len > 14) f[14] = kind_sel ? {4'd6, 4'($urandom)} :
                        {4'd4, ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd5};
    if (kind_sel == 0 && len > 23) f[23] = pr;
    if (kind_sel == 1 && len > 20) f[20] = pr;
    if (same_addr)
      for (int i = 0; i < (kind_sel ? 16 : 4); i++) begin
        int sp = kind_sel ? 22 + i : 26 + i;
        if (sp + (kind_sel ? 16 : 4) < len) f[sp + (kind_sel ? 16 : 4)] = f[sp];
      end
  endfunction

  // drops the input and holds off until every key has left
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (key_q.size() != 0);
  endtask

  task automatic test_v4_keys();
    logic [7:0] f[$];
    make_frame(f, 0, PROTO_TCP, 54, 0);  send_frame(f);
    make_frame(f, 0, 8'd99, 34, 1);      send_frame(f);  // equal addresses, other protocol
  endtask

  task automatic test_v6_keys();
    logic [7:0] f[$];
    make_frame(f, 1, PROTO_UDP, 62, 0);  send_frame(f);
  endtask

  task automatic test_failures();
    logic [7:0] f[$];
    make_frame(f, 0, PROTO_UDP, 25, 0);  send_frame(f);  // short IPv4 header
    make_frame(f, 2, 0, 14, 0);          send_frame(f);  // no L3 at all
    make_frame(f, 2, 0, 1, 0);           send_frame(f);
    f = '{8'hFF, 8'h00}; send_frame(f);
  endtask

  // saturation of the capture length with one oversized frame
  task automatic test_long_frame();
    logic [7:0] f[$];
    make_frame(f, 0, PROTO_ICMP, TbMaxCapture + 4, 0);
    send_frame(f);
  endtask

  initial begin
    clear_frame();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_v4_keys();
    test_v6_keys();
    wait_drained();      // sender holds off until every key has left
    test_failures();
    test_long_frame();
    wait_drained();
    stim_done = 1;
  end

  // receiver: field-by-field compare of each key byte, then a drawn stall
  always @(posedge clk) begin
    key_beat_t got, want;
    cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tlast, m_axis_tuser, m_axis_tdata[8],
             m_axis_tdata[15:9], m_axis_tdata[23:16]};
      if (key_q.size() == 0) begin
        $error("key byte with nothing expected: %h", got.kbyte); errors++;
      end else begin
        want = key_q.pop_front();
        if (got.kbyte !== want.kbyte) begin
          $error("key_byte exp %h got %h", want.kbyte, got.kbyte); errors++; end
        if (got.klast !== want.klast) begin
          $error("key_last exp %b got %b", want.klast, got.klast); errors++; end
        if (got.ok !== want.ok) begin
          $error("key_ok exp %b got %b", want.ok, got.ok); errors++; end
        if (got.kept !== want.kept) begin
          $error("order_kept exp %b got %b", want.kept, got.kept); errors++; end
        if (got.l4_off !== want.l4_off) begin
          $error("l4_start exp %0d got %0d", want.l4_off, got.l4_off); errors++; end
        if (got.pay_off !== want.pay_off) begin
          $error("pay_start exp %0d got %0d", want.pay_off, got.pay_off); errors++; end
      end
      rx_wait = $urandom_range(0, 7);
    end
    if (rx_wait != 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    wait (stim_done);
    while (key_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    wait (cycles > 40000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
